### src/temp_humidity_compensation_unit_defines.svh
// Assertion macros shared by the compensation unit RTL.
`ifndef TEMP_HUMIDITY_COMPENSATION_UNIT_DEFINES_SVH
`define TEMP_HUMIDITY_COMPENSATION_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define THC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define THC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/thc_pkg.sv
// Shared types and constants of the temperature/humidity compensation unit.
package thc_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [19:0] RAW_TEMP_SKIP = 20'h80000;
  localparam logic [15:0] RAW_HUM_SKIP  = 16'h8000;

  localparam logic signed [16:0] TEMP_MIN_CENTI = -17'sd4000;
  localparam logic signed [16:0] TEMP_MAX_CENTI = 17'sd8500;
  localparam logic [16:0]        HUM_Q10_MAX    = 17'd102400;
  localparam logic signed [31:0] HUM_ACC_MAX    = 32'sd419430400;

  localparam logic signed [22:0] FINE_OFFSET = 23'sd76800;
  localparam logic signed [24:0] TEMP_ROUND  = 25'sd128;
  localparam logic [31:0]        HUM_A_ROUND = 32'd16384;
  localparam logic signed [20:0] HUM_C_BIAS  = 21'sd32768;
  localparam logic signed [22:0] HUM_S_BIAS  = 23'sd2097152;
  localparam logic [31:0]        HUM_E_ROUND = 32'd8192;

  typedef enum logic [2:0] {
    REG_TEMP_CAL_1   = 3'd0,
    REG_TEMP_CAL_2   = 3'd1,
    REG_TEMP_CAL_3   = 3'd2,
    REG_HUM_CAL_1    = 3'd3,
    REG_HUM_CAL_2    = 3'd4,
    REG_HUM_CAL_3    = 3'd5,
    REG_HUM_CAL_4_5  = 3'd6,
    REG_HUM_CAL_6    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        hum_q10;
    logic               raw_ok;
    logic               temp_ok;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic [11:0]        h4;
    logic [11:0]        h5;
    logic signed [7:0]  h6;
  } cal_t;

  // Handoff from the temperature stages to the humidity stages.
  typedef struct packed {
    logic signed [21:0] fine;
    logic [31:0]        a_pre;
    logic               skip;
  } fine_t;

endpackage

### src/thc_regs.sv
// Calibration register file behind the APB-style port.
module thc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [thc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output thc_pkg::cal_t              cal
);
  import thc_pkg::*;

  logic [15:0] temp_cal_1;
  logic [15:0] temp_cal_2;
  logic [15:0] temp_cal_3;
  logic [7:0]  hum_cal_1;
  logic [15:0] hum_cal_2;
  logic [7:0]  hum_cal_3;
  logic [23:0] hum_cal_4_5;
  logic [7:0]  hum_cal_6;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_1  <= '0;
      temp_cal_2  <= '0;
      temp_cal_3  <= '0;
      hum_cal_1   <= '0;
      hum_cal_2   <= '0;
      hum_cal_3   <= '0;
      hum_cal_4_5 <= '0;
      hum_cal_6   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_TEMP_CAL_1:  temp_cal_1  <= pwdata[15:0];
        REG_TEMP_CAL_2:  temp_cal_2  <= pwdata[15:0];
        REG_TEMP_CAL_3:  temp_cal_3  <= pwdata[15:0];
        REG_HUM_CAL_1:   hum_cal_1   <= pwdata[7:0];
        REG_HUM_CAL_2:   hum_cal_2   <= pwdata[15:0];
        REG_HUM_CAL_3:   hum_cal_3   <= pwdata[7:0];
        REG_HUM_CAL_4_5: hum_cal_4_5 <= pwdata[23:0];
        REG_HUM_CAL_6:   hum_cal_6   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TEMP_CAL_1:  prdata = {16'd0, temp_cal_1};
      REG_TEMP_CAL_2:  prdata = {16'd0, temp_cal_2};
      REG_TEMP_CAL_3:  prdata = {16'd0, temp_cal_3};
      REG_HUM_CAL_1:   prdata = {24'd0, hum_cal_1};
      REG_HUM_CAL_2:   prdata = {16'd0, hum_cal_2};
      REG_HUM_CAL_3:   prdata = {24'd0, hum_cal_3};
      REG_HUM_CAL_4_5: prdata = {8'd0, hum_cal_4_5};
      REG_HUM_CAL_6:   prdata = {24'd0, hum_cal_6};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cal.t1 = temp_cal_1;
    cal.t2 = $signed(temp_cal_2);
    cal.t3 = $signed(temp_cal_3);
    cal.h1 = hum_cal_1;
    cal.h2 = $signed(hum_cal_2);
    cal.h3 = hum_cal_3;
    cal.h4 = hum_cal_4_5[23:12];
    cal.h5 = hum_cal_4_5[11:0];
    cal.h6 = $signed(hum_cal_6);
  end

endmodule

### src/thc_temp_pipe.sv
// Temperature stages: raw sample to fine-temperature term, four registers deep.
module thc_temp_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  thc_pkg::in_item_t sample,
  input  thc_pkg::cal_t     cal,
  output logic              out_valid,
  output thc_pkg::fine_t    fine_o
);
  import thc_pkg::*;

  logic [3:0] vld;

  // stage 1
  logic signed [17:0] a1;
  logic signed [16:0] d1;
  logic [31:0]        apre1;
  logic               skip1;
  // stage 2
  logic signed [20:0] v1_2;
  logic signed [19:0] dds2;
  logic [31:0]        apre2;
  logic               skip2;
  // stage 3
  logic signed [20:0] v1_3;
  logic signed [17:0] v2_3;
  logic [31:0]        apre3;
  logic               skip3;

  logic signed [17:0] a1_next;
  logic signed [16:0] d_next;
  logic signed [33:0] p1;
  logic signed [33:0] pdd;
  logic signed [35:0] p2;
  logic signed [21:0] fine_next;

  assign a1_next   = $signed({1'b0, sample.raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign d_next    = $signed({1'b0, sample.raw_temp[19:4]}) - $signed({1'b0, cal.t1});
  assign p1        = a1 * cal.t2;
  assign pdd       = d1 * d1;
  assign p2        = dds2 * cal.t3;
  assign fine_next = v1_3 + v2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a1_next;
      d1    <= d_next;
      apre1 <= {2'b00, sample.raw_hum, 14'd0} - {cal.h4, 20'd0};
      skip1 <= (sample.raw_temp == RAW_TEMP_SKIP) || (sample.raw_hum == RAW_HUM_SKIP);

      v1_2  <= p1[31:11];
      dds2  <= pdd[31:12];
      apre2 <= apre1;
      skip2 <= skip1;

      v1_3  <= v1_2;
      v2_3  <= p2[31:14];
      apre3 <= apre2;
      skip3 <= skip2;

      fine_o.fine  <= fine_next;
      fine_o.a_pre <= apre3;
      fine_o.skip  <= skip3;
    end
  end

  assign out_valid = vld[3];

endmodule

### src/thc_hum_pipe.sv
// Humidity stages and result formatting, eleven registers deep.
module thc_hum_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  thc_pkg::fine_t     fine_i,
  input  thc_pkg::cal_t      cal,
  output logic               out_valid,
  output thc_pkg::out_item_t result
);
  import thc_pkg::*;

  logic [10:0] vld;

  logic signed [22:0] x5;
  logic signed [16:0] tc5, tc6, tc7, tc8, tc9, tc10, tc11, tc12, tc13, tc14;
  logic               skip5, skip6, skip7, skip8, skip9, skip10, skip11, skip12, skip13, skip14;
  logic               tok6, tok7, tok8, tok9, tok10, tok11, tok12, tok13, tok14;
  logic [31:0]        apre5, apre6;
  logic [31:0]        h5x6;
  logic signed [30:0] xh6_6;
  logic signed [31:0] xh3_6;
  logic signed [16:0] a7, a8, a9, a10, a11;
  logic signed [20:0] b7, c7;
  logic [31:0]        bc8;
  logic signed [22:0] s9;
  logic [31:0]        sp10;
  logic signed [17:0] e11;
  logic [31:0]        x12, x13, x14;
  logic [31:0]        sq13;
  logic [31:0]        m14;

  logic signed [22:0] x_next;
  logic signed [24:0] t5;
  logic signed [35:0] ph5;
  logic signed [30:0] ph6;
  logic signed [31:0] ph3;
  logic [31:0]        asum;
  logic signed [20:0] c_next;
  logic signed [41:0] pbc;
  logic signed [22:0] s_next;
  logic signed [38:0] ps;
  logic [31:0]        esum;
  logic signed [34:0] px;
  logic signed [16:0] q;
  logic signed [33:0] pq;
  logic signed [33:0] pm;
  logic [31:0]        x3;
  logic [16:0]        hum_next;

  assign x_next = fine_i.fine - FINE_OFFSET;
  assign t5     = fine_i.fine * 25'sd5 + TEMP_ROUND;
  assign ph5    = x5 * $signed({1'b0, cal.h5});
  assign ph6    = x5 * cal.h6;
  assign ph3    = x5 * $signed({1'b0, cal.h3});
  assign asum   = apre6 - h5x6 + HUM_A_ROUND;
  assign c_next = $signed(xh3_6[31:11]) + HUM_C_BIAS;
  assign pbc    = b7 * c7;
  assign s_next = $signed(bc8[31:10]) + HUM_S_BIAS;
  assign ps     = s9 * cal.h2;
  assign esum   = sp10 + HUM_E_ROUND;
  assign px     = a11 * e11;
  assign q      = $signed(x12[31:15]);
  assign pq     = q * q;
  assign pm     = $signed(sq13[31:7]) * $signed({1'b0, cal.h1});
  assign x3     = x14 - {{4{m14[31]}}, m14[31:4]};

  // Clamp the accumulator to 0..HUM_ACC_MAX, then drop the low twelve bits.
  always_comb begin
    if (x3[31]) begin
      hum_next = '0;
    end else if ($signed(x3) > HUM_ACC_MAX) begin
      hum_next = HUM_Q10_MAX;
    end else begin
      hum_next = x3[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5    <= x_next;
      tc5   <= t5[24:8];
      apre5 <= fine_i.a_pre;
      skip5 <= fine_i.skip;

      h5x6  <= ph5[31:0];
      xh6_6 <= ph6;
      xh3_6 <= ph3;
      apre6 <= apre5;
      tc6   <= tc5;
      tok6  <= (tc5 >= TEMP_MIN_CENTI) && (tc5 <= TEMP_MAX_CENTI);
      skip6 <= skip5;

      a7    <= asum[31:15];
      b7    <= xh6_6[30:10];
      c7    <= c_next;

      bc8   <= pbc[31:0];
      s9    <= s_next;
      sp10  <= ps[31:0];
      e11   <= esum[31:14];
      x12   <= px[31:0];
      sq13  <= pq[31:0];
      m14   <= pm[31:0];

      a8  <= a7;  a9  <= a8;  a10 <= a9;  a11 <= a10;
      x13 <= x12; x14 <= x13;

      tc7  <= tc6;  tc8  <= tc7;  tc9  <= tc8;  tc10 <= tc9;
      tc11 <= tc10; tc12 <= tc11; tc13 <= tc12; tc14 <= tc13;
      tok7  <= tok6;  tok8  <= tok7;  tok9  <= tok8;  tok10 <= tok9;
      tok11 <= tok10; tok12 <= tok11; tok13 <= tok12; tok14 <= tok13;
      skip7  <= skip6;  skip8  <= skip7;  skip9  <= skip8;  skip10 <= skip9;
      skip11 <= skip10; skip12 <= skip11; skip13 <= skip12; skip14 <= skip13;

      // Skip marker zeroes every field; out-of-range temperature zeroes its own.
      result.temp_centi <= (skip14 || !tok14) ? '0 : tc14[14:0];
      result.hum_q10    <= skip14 ? '0 : hum_next;
      result.raw_ok     <= !skip14;
      result.temp_ok    <= !skip14 && tok14;
    end
  end

  assign out_valid = vld[10];

endmodule

### src/temp_humidity_compensation_unit.sv
// Throughput: one item per cycle while no result item is stalled; no stage chains two multiplies.
// The whole pipeline advances together and freezes while a result item is stalled.
// Reset (rst, synchronous, active high) clears the calibration registers to zero
// and empties the pipeline; data registers keep whatever they held.
module temp_humidity_compensation_unit (
  input  logic                       clk,
  input  logic                       rst,
  // calibration register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [thc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // sample items in
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  thc_pkg::in_item_t          sample,
  // result items out
  output logic                       result_valid,
  input  logic                       result_stall,
  output thc_pkg::out_item_t         result
);
  import thc_pkg::*;
  `include "temp_humidity_compensation_unit_defines.svh"

  cal_t  cal;
  fine_t fine;
  logic  fine_valid;
  logic  en;

  // Result item properties used by the checks below.
  logic  skip_item;
  logic  temp_bad;
  logic  temp_good;
  logic  all_zero;
  logic  temp_zero;
  logic  temp_in_range;
  logic  hum_in_scale;

  // Advance every stage unless the result register holds an item the sink
  // refuses. Bubbles ride along with their valid bit low, so no item is
  // dropped or duplicated while frozen.
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // Calibration registers; configuration is to be written only while idle, which the block does not enforce.
  thc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  // Stages 1-4: offset terms, linear and square products, fine temperature.
  // The humidity offset difference and the skip-marker check are formed in
  // stage 1 and carried alongside.
  thc_temp_pipe u_temp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample_valid),
    .sample    (sample),
    .cal       (cal),
    .out_valid (fine_valid),
    .fine_o    (fine)
  );

  // Stages 5-15: centidegree scaling and range check, then the chain of
  // humidity products (never two chained in one stage), clamp and result register.
  thc_hum_pipe u_hum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fine_valid),
    .fine_i    (fine),
    .cal       (cal),
    .out_valid (result_valid),
    .result    (result)
  );

  assign skip_item     = result_valid && !result.raw_ok;
  assign temp_bad      = result_valid && !result.temp_ok;
  assign temp_good     = result_valid && result.temp_ok;
  assign all_zero      = (result.temp_centi == '0) && (result.hum_q10 == '0) && !result.temp_ok;
  assign temp_zero     = (result.temp_centi == '0);
  assign temp_in_range = (result.temp_centi >= TEMP_MIN_CENTI) &&
                         (result.temp_centi <= TEMP_MAX_CENTI);
  assign hum_in_scale  = (result.hum_q10 <= HUM_Q10_MAX);

  // A skipped sample gives an all-zero result item.
  `THC_ASSERT_NOW(a_skip_zero, skip_item, all_zero, "skipped item with nonzero fields")
  // Temperature outside its range reads as zero.
  `THC_ASSERT_NOW(a_temp_bad_zero, temp_bad, temp_zero, "bad temperature not zeroed")
  // A good temperature lies within the range.
  `THC_ASSERT_NOW(a_temp_range, temp_good, temp_in_range, "temperature out of range")
  // Humidity never exceeds full scale.
  `THC_ASSERT_NOW(a_hum_max, result_valid, hum_in_scale, "humidity above full scale")
  // A frozen pipeline keeps its result item on the next cycle.
  `THC_ASSERT_NEXT(a_freeze_hold, !en, result_valid && (result == $past(result)), "result lost")

endmodule

### sim/temp_humidity_compensation_unit_tb.sv
// Self-checking testbench for the temperature/humidity compensation unit.
`timescale 1ns / 1ps

module temp_humidity_compensation_unit_tb;
  import thc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 sample_valid;
  logic                 sample_stall;
  in_item_t             sample;
  logic                 result_valid;
  logic                 result_stall;
  out_item_t            result;

  // Shadow copy of the calibration registers, updated on every accepted write.
  logic [31:0]          cal_shadow [8];
  // Compensated results still owed by the block, oldest first.
  out_item_t            owed_results [$];

  int                   fail_count = 0;
  bit                   sender_gaps = 1'b1;
  bit                   receiver_stalls = 1'b1;
  int                   hold_request = 0;

  temp_humidity_compensation_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned sh);
    sra32 = $signed(v) >>> sh;
  endfunction

  function automatic logic [31:0] cal_mask(input reg_idx_t idx);
    case (idx) inside
      REG_HUM_CAL_1, REG_HUM_CAL_3, REG_HUM_CAL_6: cal_mask = 32'h0000_00FF;
      REG_HUM_CAL_4_5:                             cal_mask = 32'h00FF_FFFF;
      default:                                     cal_mask = 32'h0000_FFFF;
    endcase
  endfunction

  // Compensate one sample pair with the shadow calibration. All arithmetic
  // wraps at 32 bits; shifts right through sra32 are arithmetic.
  function automatic out_item_t compensate(input in_item_t s);
    logic [31:0]        rt, rh, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0]        v1, v2, d, fine, tc, x, a, b, c, e;
    logic signed [31:0] temp, acc;
    logic [31:0]        hum;
    logic               in_range;
    out_item_t          r;
    r = '0;
    if (s.raw_temp == RAW_TEMP_SKIP || s.raw_hum == RAW_HUM_SKIP)
      return r;
    rt = {12'd0, s.raw_temp};
    rh = {16'd0, s.raw_hum};
    t1 = cal_shadow[REG_TEMP_CAL_1];
    t2 = {{16{cal_shadow[REG_TEMP_CAL_2][15]}}, cal_shadow[REG_TEMP_CAL_2][15:0]};
    t3 = {{16{cal_shadow[REG_TEMP_CAL_3][15]}}, cal_shadow[REG_TEMP_CAL_3][15:0]};
    h1 = cal_shadow[REG_HUM_CAL_1];
    h2 = {{16{cal_shadow[REG_HUM_CAL_2][15]}}, cal_shadow[REG_HUM_CAL_2][15:0]};
    h3 = cal_shadow[REG_HUM_CAL_3];
    h4 = {20'd0, cal_shadow[REG_HUM_CAL_4_5][23:12]};
    h5 = {20'd0, cal_shadow[REG_HUM_CAL_4_5][11:0]};
    h6 = {{24{cal_shadow[REG_HUM_CAL_6][7]}}, cal_shadow[REG_HUM_CAL_6][7:0]};

    // fine temperature and hundredths of a degree
    v1   = sra32(((rt >> 3) - (t1 << 1)) * t2, 11);
    d    = (rt >> 4) - t1;
    v2   = sra32(sra32(d * d, 12) * t3, 14);
    fine = v1 + v2;
    tc   = sra32(fine * 32'd5 + 32'd128, 8);
    temp = $signed(tc);
    in_range = (temp >= TEMP_MIN_CENTI) && (temp <= TEMP_MAX_CENTI);

    // humidity accumulator, driven by the same fine temperature
    x   = fine - 32'd76800;
    a   = sra32((rh << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    b   = sra32(x * h6, 10);
    c   = sra32(x * h3, 11) + 32'd32768;
    e   = sra32((sra32(b * c, 10) + 32'd2097152) * h2 + 32'd8192, 14);
    x   = a * e;
    x   = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
    acc = $signed(x);
    if (acc < 0)
      acc = 0;
    if (acc > HUM_ACC_MAX)
      acc = HUM_ACC_MAX;
    hum = 32'(acc) >> 12;

    r.temp_centi = in_range ? tc[14:0] : '0;
    r.hum_q10    = hum[16:0];
    r.raw_ok     = 1'b1;
    r.temp_ok    = in_range;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result item with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result item with nothing owed: temp=%0d hum=%0d raw_ok=%0b temp_ok=%0b",
                   $realtime, result.temp_centi, result.hum_q10, result.raw_ok, result.temp_ok);
      end else begin
        want = owed_results.pop_front();
        if (result.temp_centi !== want.temp_centi || result.hum_q10 !== want.hum_q10 ||
            result.raw_ok !== want.raw_ok || result.temp_ok !== want.temp_ok) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch temp=%0d/%0d hum=%0d/%0d raw_ok=%0b/%0b temp_ok=%0b/%0b (exp/act)",
                     $realtime, want.temp_centi, result.temp_centi, want.hum_q10, result.hum_q10,
                     want.raw_ok, result.raw_ok, want.temp_ok, result.temp_ok);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: per item, hold stall for a randomly drawn wait, then take one result item.
  // A hold request stretches one of these waits into a long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int wait_cycles;
    result_stall = 1'b0;
    forever begin
      wait_cycles = receiver_stalls ? $urandom_range(0, 6) : 0;
      if (hold_request > 0) begin
        wait_cycles = hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        result_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      result_stall = 1'b0;
      // keep stall low until the next result item goes through
      do @(posedge clk); while (rst || !result_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Write one calibration register through a setup and an access cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    cal_shadow[idx] = value & cal_mask(idx);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_calibration(input logic [31:0] t1, input logic [31:0] t2,
                                 input logic [31:0] t3, input logic [31:0] h1,
                                 input logic [31:0] h2, input logic [31:0] h3,
                                 input logic [31:0] h45, input logic [31:0] h6);
    write_reg(REG_TEMP_CAL_1, t1);
    write_reg(REG_TEMP_CAL_2, t2);
    write_reg(REG_TEMP_CAL_3, t3);
    write_reg(REG_HUM_CAL_1, h1);
    write_reg(REG_HUM_CAL_2, h2);
    write_reg(REG_HUM_CAL_3, h3);
    write_reg(REG_HUM_CAL_4_5, h45);
    write_reg(REG_HUM_CAL_6, h6);
  endtask

  // Offer one sample item after a random gap and hold it until accepted.
  // Valid stays high into the next item when that item has no gap.
  task automatic send_sample(input logic [19:0] raw_temp, input logic [15:0] raw_hum);
    int        gap;
    in_item_t  s;
    s.raw_temp = raw_temp;
    s.raw_hum  = raw_hum;
    gap = sender_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       = s;
    sample_valid = 1'b1;
    do @(posedge clk); while (sample_stall);
    owed_results.push_back(compensate(s));
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has arrived, then let the
  // pipeline settle before the calibration may change.
  task automatic wait_drained();
    sample_valid = 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random sample pair: skip markers now and then, about half the temperatures
  // near the usual operating range, the rest over the full field.
  task automatic send_random_sample();
    int          pick;
    logic [19:0] rt;
    logic [15:0] rh;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      rt = RAW_TEMP_SKIP;
    else if (pick < 55)
      rt = 20'($urandom_range(350000, 650000));
    else
      rt = 20'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5)
      rh = RAW_HUM_SKIP;
    else
      rh = 16'($urandom);
    send_sample(rt, rh);
  endtask

  // Calibration close to a typical part, perturbed.
  task automatic set_typical_calibration();
    set_calibration(32'($urandom_range(25000, 30000)), 32'($urandom_range(24000, 28000)),
                    -32'($urandom_range(0, 2000)), 32'($urandom_range(0, 255)),
                    32'($urandom_range(200, 500)), 32'($urandom_range(0, 255)),
                    (32'($urandom_range(200, 400)) << 12) | 32'($urandom_range(0, 100)),
                    32'($urandom_range(0, 60)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Calibration is all zero after reset.
  task automatic test_reset_calibration();
    send_sample(20'd519888, 16'd30000);
    send_sample(RAW_TEMP_SKIP, 16'd1000);
    repeat (6) send_random_sample();
  endtask

  // Field extremes, skip markers, temperature out of range, humidity clamps.
  task automatic test_directed();
    wait_drained();
    set_calibration(32'd27504, 32'd26435, -32'd1000, 32'd75, 32'd362, 32'd0,
                    (32'd313 << 12) | 32'd50, 32'd30);
    send_sample(20'd519888, 16'd30000);
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(RAW_TEMP_SKIP, 16'd30000);
    send_sample(20'd519888, RAW_HUM_SKIP);
    send_sample(RAW_TEMP_SKIP, RAW_HUM_SKIP);
    send_sample(20'h7FFFF, 16'h7FFF);
    send_sample(20'h80001, 16'h8001);
    send_sample(20'd200000, 16'd30000);   // far below minus 40 degrees
    send_sample(20'd800000, 16'd30000);   // far above 85 degrees
    send_sample(20'd519888, 16'hFFFF);    // humidity clamps high
    send_sample(20'd519888, 16'd0);       // humidity clamps low
    send_sample(20'd420000, 16'd25000);
    send_sample(20'd620000, 16'd40000);
  endtask

  // Calibration registers at their extremes.
  task automatic test_calibration_extremes();
    wait_drained();
    set_calibration('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (4) send_random_sample();
    send_sample(20'hFFFFF, 16'hFFFF);
    wait_drained();
    set_calibration(32'h0, 32'h8000, 32'h8000, 32'h0, 32'h8000, 32'h0, 32'h0, 32'h80);
    repeat (4) send_random_sample();
    send_sample(20'h0, 16'h0);
    wait_drained();
    set_calibration(32'hFFFF, 32'h7FFF, 32'h7FFF, 32'hFF, 32'h7FFF, 32'hFF, 32'hFFFFFF, 32'h7F);
    repeat (4) send_random_sample();
  endtask

  // Bulk random items under changing calibration and idling patterns.
  task automatic test_random_calibrations();
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      if (phase % 2 == 0)
        set_typical_calibration();
      else
        set_calibration($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
      if (phase == 3) begin
        // one phase at full rate on both sides
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
      end else begin
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      repeat (80) send_random_sample();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // pipeline fills and stalls its input.
  task automatic test_backpressure();
    wait_drained();
    set_typical_calibration();
    sender_gaps  = 1'b0;
    hold_request = 300;
    repeat (80) send_random_sample();
    sender_gaps  = 1'b1;
  endtask

  // Pause the sender until everything owed has come back, then resume.
  task automatic test_drain_pause();
    repeat (20) send_random_sample();
    sample_valid = 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (20) send_random_sample();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample       = '0;
    for (int i = 0; i < 8; i++)
      cal_shadow[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_calibration();
    test_directed();
    test_calibration_extremes();
    test_random_calibrations();
    test_backpressure();
    test_drain_pause();

    // drain, then give the pipeline time to show any stray result item
    sample_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
